[design/brf_pkg.sv]
// Shared types and constants for the circular byte FIFO with line reads.
`timescale 1ns / 1ps

package brf_pkg;

    // Field widths fixed by the interface
    localparam int REQ_W  = 2;
    localparam int DATA_W = 8;
    localparam int LEN_W  = 7;
    localparam int FILL_W = 11;

    // Defaults for the top-level parameters
    localparam int DEPTH_DEF    = 1024;
    localparam int MAX_READ_DEF = 64;

    // Delimiter after reset (newline)
    localparam logic [DATA_W-1:0] DELIM_RST = 8'd10;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_LINE  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP,
        ST_EMPTY
    } t_state;

    // One result beat as it travels to the output queue
    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              acc;
        logic              last;
        logic              valid;
        logic [DATA_W-1:0] data;
    } t_beat;

endpackage

[design/brf_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/brf_outq.sv]
// Two-entry result queue that decouples the sequencer from output stalls.
`timescale 1ns / 1ps

module brf_outq
    import brf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_beat       i_beat,
    input  logic        i_pop,
    output logic [1:0]  o_count,
    output logic        o_valid,
    output t_beat       o_head
);

    t_beat      r_slot [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;
    logic [1:0] n_count;

    // Store an incoming beat
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_beat;
        end
    end

    // Track pointers and occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_slot[r_rd];

endmodule

[design/byte_ring_fifo_line_read_core.sv]
// Top level: circular byte FIFO with byte reads, line reads and clear.
//
//  Channel  | Dir | Beat fields (low bit up)                              | Beat per
//  ---------+-----+-------------------------------------------------------+----------
//  s_axis   | in  | tuser: req_type; tdata: data_in, max_len, pad          | request
//  m_axis   | out | tuser: data_valid; tlast: last;                        | result
//           |     | tdata: data_out, write_accepted, fill_level, pad       |
//  cfg      | in  | i_cfg_wr_en / i_cfg_wr_data: delimiter                  | write
//
// A read of N bytes issues N pops on the RAM read port, one byte per cycle
// while the result queue has room, and the last byte returns before the next
// request is taken. A line read first scans the store one byte per cycle
// from the read pointer until the delimiter or the end of the fill level;
// a found line is then popped as a plain read capped by max_len, else one
// empty beat is returned. Synchronous reset clears pointers and control;
// the byte store is not cleared. Output stalls hold pops through the
// two-entry result queue; requests are taken only when the sequencer is idle.
`timescale 1ns / 1ps

module byte_ring_fifo_line_read_core
    import brf_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int MAX_READ = MAX_READ_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,   // data_in[7:0], max_len[14:8], pad[15]
    input  logic [REQ_W-1:0]  s_axis_tuser,   // req_type[1:0]
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // data_out[7:0], write_accepted[8],
                                              // fill_level[19:9], pad[23:20]
    output logic [0:0]        m_axis_tuser,   // data_valid[0]
    output logic              m_axis_tlast,
    // delimiter register
    input  logic              i_cfg_wr_en,
    input  logic [DATA_W-1:0] i_cfg_wr_data
);

    localparam int IW   = $clog2(DEPTH);
    localparam int PW   = IW + 1;
    localparam int TOPP = 2 * DEPTH - 1;
    localparam int MW   = (PW > LEN_W) ? PW : LEN_W;
    localparam int XW   = (PW > FILL_W) ? PW : FILL_W;

    // Pointer helpers
    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        return (p == PW'(TOPP)) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [IW-1:0] ptr_index(input logic [PW-1:0] p);
        logic [PW-1:0] d;
        d = p - PW'(DEPTH);
        return (p >= PW'(DEPTH)) ? d[IW-1:0] : p[IW-1:0];
    endfunction

    function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] wp,
                                              input logic [PW-1:0] rp);
        logic [PW:0] s;
        s = {1'b0, wp} + (PW+1)'(2 * DEPTH) - {1'b0, rp};
        return (wp >= rp) ? (wp - rp) : s[PW-1:0];
    endfunction

    function automatic logic [FILL_W-1:0] fill_out(input logic [PW-1:0] f);
        logic [XW-1:0] x;
        x = XW'(f);
        return x[FILL_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] min_len(input logic [LEN_W-1:0] a,
                                                 input logic [PW-1:0]    b);
        logic [MW-1:0] ax;
        logic [MW-1:0] bx;
        ax = MW'(a);
        bx = MW'(b);
        return (bx < ax) ? b[LEN_W-1:0] : a;
    endfunction

    // Request fields
    logic [DATA_W-1:0] req_data;
    logic [LEN_W-1:0]  req_len;
    logic [LEN_W-1:0]  len_sat;
    t_req              req_type;

    assign req_data = s_axis_tdata[7:0];
    assign req_len  = s_axis_tdata[14:8];
    assign req_type = t_req'(s_axis_tuser);
    assign len_sat  = (req_len > LEN_W'(MAX_READ)) ? LEN_W'(MAX_READ) : req_len;

    // Registers
    t_state            r_state;
    t_state            n_state;
    logic [PW-1:0]     r_wp;
    logic [PW-1:0]     n_wp;
    logic [PW-1:0]     r_rp;
    logic [PW-1:0]     n_rp;
    logic [DATA_W-1:0] r_delim;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  n_len;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  n_rem;
    logic [PW-1:0]     r_cnt;
    logic [PW-1:0]     n_cnt;
    logic [PW-1:0]     r_sp;
    logic [PW-1:0]     n_sp;
    logic [PW-1:0]     r_ic;
    logic [PW-1:0]     n_ic;
    logic              r_sv;
    logic              n_sv;
    logic [PW-1:0]     r_si;
    logic [PW-1:0]     n_si;
    logic              r_rd_pend;
    logic              n_rd_pend;
    logic              r_pend_last;
    logic              n_pend_last;
    logic [FILL_W-1:0] r_pend_fill;
    logic [FILL_W-1:0] n_pend_fill;

    // RAM and queue hookup
    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    logic              ram_re;
    logic [IW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              q_push;
    t_beat             q_beat;
    logic              q_pop;
    logic [1:0]        q_count;
    logic              q_valid;
    t_beat             q_head;

    // Shared decode
    logic [PW-1:0]     count;
    logic              room;
    logic [1:0]        occ;
    logic              accept;
    logic [LEN_W-1:0]  rd_n;
    logic              line_skip;
    logic              match;
    logic              scan_done;
    logic [PW-1:0]     line_len;
    logic [LEN_W-1:0]  scan_n;
    logic              pop_go;
    logic              scan_go;

    assign count     = fill_of(r_wp, r_rp);
    assign occ       = q_count + {1'b0, r_rd_pend} - {1'b0, q_pop};
    assign room      = (occ < 2'd2);
    assign s_axis_tready = (r_state == ST_IDLE) && !r_rd_pend && room;
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign rd_n      = min_len(len_sat, count);
    assign line_skip = (len_sat == '0) || (count == '0);
    assign match     = (ram_rdata == r_delim);
    assign scan_done = r_sv && (match || (r_si == r_cnt - PW'(1)));
    assign line_len  = r_si + PW'(1);
    assign scan_n    = match ? min_len(r_len, line_len) : '0;
    assign pop_go    = (r_state == ST_POP) && room;
    assign scan_go   = (r_state == ST_SCAN) && (r_ic != r_cnt);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (req_type)
                        REQ_READ: begin
                            if (rd_n != '0) begin
                                n_state = ST_POP;
                            end
                        end
                        REQ_LINE: begin
                            if (!line_skip) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    n_state = (scan_n == '0) ? ST_EMPTY : ST_POP;
                end
            end
            ST_POP: begin
                if (pop_go && (r_rem == LEN_W'(1))) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (room) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath control
    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_len       = r_len;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_sp        = r_sp;
        n_ic        = r_ic;
        n_sv        = 1'b0;
        n_si        = r_si;
        n_rd_pend   = 1'b0;
        n_pend_last = r_pend_last;
        n_pend_fill = r_pend_fill;
        ram_we      = 1'b0;
        ram_waddr   = ptr_index(r_wp);
        ram_re      = 1'b0;
        ram_raddr   = ptr_index(r_rp);
        q_push      = 1'b0;
        q_beat      = '{fill: fill_out(count), acc: 1'b0, last: 1'b1,
                        valid: 1'b0, data: '0};

        case (r_state)
            ST_IDLE: begin
                // Take a request: single-beat answers go straight to the queue
                if (accept) begin
                    case (req_type)
                        REQ_WRITE: begin
                            q_push = 1'b1;
                            if (count < PW'(DEPTH)) begin
                                ram_we      = 1'b1;
                                n_wp        = ptr_next(r_wp);
                                q_beat.acc  = 1'b1;
                                q_beat.fill = fill_out(count + PW'(1));
                            end
                        end
                        REQ_CLEAR: begin
                            n_wp        = '0;
                            n_rp        = '0;
                            q_push      = 1'b1;
                            q_beat.fill = '0;
                        end
                        REQ_READ: begin
                            n_rem  = rd_n;
                            q_push = (rd_n == '0);
                        end
                        REQ_LINE: begin
                            n_len  = len_sat;
                            n_cnt  = count;
                            n_sp   = r_rp;
                            n_ic   = '0;
                            q_push = line_skip;
                        end
                        default: q_push = 1'b0;
                    endcase
                end
            end
            ST_SCAN: begin
                // Read ahead one byte per cycle and compare on return
                if (scan_go) begin
                    ram_re    = 1'b1;
                    ram_raddr = ptr_index(r_sp);
                    n_sp      = ptr_next(r_sp);
                    n_ic      = r_ic + PW'(1);
                    n_si      = r_ic;
                    n_sv      = 1'b1;
                end
                if (scan_done) begin
                    n_rem = scan_n;
                end
            end
            ST_POP: begin
                // Issue one pop when the queue has a slot for its data
                if (pop_go) begin
                    ram_re      = 1'b1;
                    n_rp        = ptr_next(r_rp);
                    n_rem       = r_rem - LEN_W'(1);
                    n_rd_pend   = 1'b1;
                    n_pend_last = (r_rem == LEN_W'(1));
                    n_pend_fill = fill_out(fill_of(r_wp, ptr_next(r_rp)));
                end
            end
            ST_EMPTY: begin
                q_push = room;
            end
            default: q_push = 1'b0;
        endcase

        // Popped byte returns from the RAM in the cycle after issue
        if (r_rd_pend) begin
            q_push = 1'b1;
            q_beat = '{fill: r_pend_fill, acc: 1'b0, last: r_pend_last,
                       valid: 1'b1, data: ram_rdata};
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wp      <= '0;
            r_rp      <= '0;
            r_delim   <= DELIM_RST;
            r_sv      <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_sv      <= n_sv;
            r_rd_pend <= n_rd_pend;
            if (i_cfg_wr_en) begin
                r_delim <= i_cfg_wr_data;
            end
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        r_len       <= n_len;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_sp        <= n_sp;
        r_ic        <= n_ic;
        r_si        <= n_si;
        r_pend_last <= n_pend_last;
        r_pend_fill <= n_pend_fill;
    end

    brf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (req_data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign q_pop = q_valid && m_axis_tready;

    brf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_beat  (q_beat),
        .i_pop   (q_pop),
        .o_count (q_count),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Pack the result beat
    assign m_axis_tvalid = q_valid;
    assign m_axis_tdata  = {4'd0, q_head.fill, q_head.acc, q_head.data};
    assign m_axis_tuser  = q_head.valid;
    assign m_axis_tlast  = q_head.last;

endmodule

[test/byte_ring_fifo_line_read_core_test.sv]
// Self-checking testbench for the circular byte FIFO with line reads.
`timescale 1ns / 1ps

module byte_ring_fifo_line_read_core_test;
    import brf_pkg::*;

    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam int READ_CAP    = MAX_READ_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 20000;
    localparam int RESET_CYCLES = 9;

    typedef struct {
        t_req              kind;
        logic [DATA_W-1:0] din;
        logic [LEN_W-1:0]  max_len;
    } fifo_req_t;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic              last;
        logic              acc;
        logic [FILL_W-1:0] fill;
    } fifo_beat_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;
    logic [REQ_W-1:0]  s_axis_tuser = REQ_WRITE;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;
    logic [0:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_wr_en = 1'b0;
    logic [DATA_W-1:0] i_cfg_wr_data = '0;

    // Requests waiting for the driver and result beats still due from the block
    fifo_req_t  request_q[$];
    fifo_beat_t due_beats[$];
    fifo_req_t  on_bus;
    logic       req_taken = 1'b0;

    // Mirror of the ring contents, pointers and delimiter
    logic [DATA_W-1:0] ring_mirror [RING_DEPTH];
    int                wr_ptr = 0;
    int                rd_ptr = 0;
    logic [DATA_W-1:0] delim = DELIM_RST;

    int   fail_count = 0;
    int   quiet_cycles = 0;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_left = 0;

    byte_ring_fifo_line_read_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Pointers run modulo twice the depth so full and empty differ
    function automatic int ptr_step(int p);
        return (p + 1 >= 2 * RING_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int ptr_slot(int p);
        return (p >= RING_DEPTH) ? p - RING_DEPTH : p;
    endfunction

    function automatic int held_bytes();
        return (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : wr_ptr + 2 * RING_DEPTH - rd_ptr;
    endfunction

    function automatic void add_due(logic [DATA_W-1:0] data, logic valid, logic last,
                                    logic acc);
        fifo_beat_t b;
        b.data  = data;
        b.valid = valid;
        b.last  = last;
        b.acc   = acc;
        b.fill  = FILL_W'(held_bytes());
        due_beats.push_back(b);
    endfunction

    // Advance the mirror by one request and queue the beats it yields
    function automatic void apply_request(fifo_req_t r);
        int count;
        int span;
        int line_len;
        int n;
        int p;
        logic acc;
        logic [DATA_W-1:0] b;
        count = held_bytes();
        case (r.kind)
            REQ_WRITE: begin
                acc = 1'b0;
                if (count < RING_DEPTH) begin
                    ring_mirror[ptr_slot(wr_ptr)] = r.din;
                    wr_ptr = ptr_step(wr_ptr);
                    acc = 1'b1;
                end
                add_due('0, 1'b0, 1'b1, acc);
            end
            REQ_CLEAR: begin
                wr_ptr = 0;
                rd_ptr = 0;
                add_due('0, 1'b0, 1'b1, 1'b0);
            end
            default: begin
                span = (r.max_len > READ_CAP) ? READ_CAP : int'(r.max_len);
                if (r.kind == REQ_LINE) begin
                    line_len = 0;
                    p = rd_ptr;
                    for (int i = 0; i < count; i++) begin
                        if (ring_mirror[ptr_slot(p)] == delim) begin
                            line_len = i + 1;
                            break;
                        end
                        p = ptr_step(p);
                    end
                    if (line_len < span) span = line_len;
                end
                n = (span < count) ? span : count;
                if (n == 0) begin
                    add_due('0, 1'b0, 1'b1, 1'b0);
                end else begin
                    for (int i = 0; i < n; i++) begin
                        b = ring_mirror[ptr_slot(rd_ptr)];
                        rd_ptr = ptr_step(rd_ptr);
                        add_due(b, 1'b1, (i == n - 1), 1'b0);
                    end
                end
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Take request beats into the mirror and check result beats
    always @(posedge i_clk) begin
        fifo_beat_t want;
        req_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) apply_request(on_bus);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (due_beats.size() == 0) begin
                $error("result beat with nothing due: tdata %h", m_axis_tdata);
                fail_count++;
            end else begin
                want = due_beats.pop_front();
                check_field("data_out", want.data, m_axis_tdata[7:0]);
                check_field("data_valid", want.valid, m_axis_tuser[0]);
                check_field("last", want.last, m_axis_tlast);
                check_field("write_accepted", want.acc, m_axis_tdata[8]);
                check_field("fill_level", want.fill, m_axis_tdata[19:9]);
            end
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Request driver: offer the next queued request, idling at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || req_taken) begin
            if (request_q.size() > 0 && !(idle_on && $urandom_range(99) < 24)) begin
                on_bus = request_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, on_bus.max_len, on_bus.din};
                s_axis_tuser  <= on_bus.kind;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done     <= 1'b1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !(idle_on && $urandom_range(99) < 24);
        end
    end

    task automatic push_req(t_req kind, int din, int max_len);
        fifo_req_t r;
        r.kind    = kind;
        r.din     = DATA_W'(din);
        r.max_len = LEN_W'(max_len);
        request_q.push_back(r);
    endtask

    // Mostly writes and short reads; some bytes match the delimiter so lines form
    task automatic push_random(int count);
        int roll;
        int din;
        int len;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(99);
            din  = ($urandom_range(4) == 0) ? int'(delim) : $urandom_range(255);
            len  = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(12);
            if (roll < 55)      push_req(REQ_WRITE, din, len);
            else if (roll < 75) push_req(REQ_READ, din, len);
            else if (roll < 98) push_req(REQ_LINE, din, len);
            else                push_req(REQ_CLEAR, din, len);
        end
    endtask

    // Hold the sender until every due beat has arrived, then let the block settle
    task automatic drain();
        while (request_q.size() != 0 || s_axis_tvalid || due_beats.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_delim(int value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= DATA_W'(value);
        delim = DATA_W'(value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Push a burst of writes, then empty the ring with long reads and a few line reads
    task automatic fill_and_empty(int writes);
        for (int i = 0; i < writes; i++)
            push_req(REQ_WRITE, ($urandom_range(15) == 0) ? int'(delim) : $urandom_range(255),
                     $urandom_range(127));
        drain();
        idle_on = 1'b1;
        for (int i = 0; i < 10; i++) begin
            if ($urandom_range(99) < 75)
                push_req(REQ_READ, $urandom_range(255), $urandom_range(40, 127));
            else
                push_req(REQ_LINE, $urandom_range(255), $urandom_range(1, 127));
        end
        drain();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty reads, extremes of data, zero and saturated lengths,
        // line past max_len, no delimiter held, clear
        push_req(REQ_READ, 0, 5);
        push_req(REQ_LINE, 0, 64);
        push_req(REQ_WRITE, 8'h00, 0);
        push_req(REQ_WRITE, 8'hFF, 127);
        push_req(REQ_WRITE, 8'h41, 0);
        push_req(REQ_WRITE, 8'h0A, 0);
        push_req(REQ_WRITE, 8'h42, 0);
        push_req(REQ_WRITE, 8'h43, 0);
        push_req(REQ_READ, 0, 0);
        push_req(REQ_LINE, 0, 64);
        push_req(REQ_LINE, 0, 64);
        push_req(REQ_WRITE, 8'h0A, 0);
        push_req(REQ_LINE, 0, 1);
        push_req(REQ_READ, 8'hFF, 127);
        push_req(REQ_WRITE, 8'h7F, 0);
        push_req(REQ_WRITE, 8'h80, 0);
        push_req(REQ_CLEAR, 8'hFF, 127);
        push_req(REQ_READ, 0, 64);
        push_req(REQ_WRITE, 8'h0A, 0);
        push_req(REQ_LINE, 0, 0);
        push_req(REQ_LINE, 0, 1);
        push_random(50);
        drain();

        set_delim(8'h00);
        push_random(40);
        drain();

        // Long receiver hold-off while writes keep coming, no idling
        set_delim(8'hFF);
        idle_on  = 1'b0;
        hold_req = 1'b1;
        fill_and_empty(30);

        set_delim($urandom_range(255));
        push_random(50);
        drain();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
